// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked assertion, disabled while in reset.
`define KRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Clocked assertion, checked during reset as well.
`define KRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define KRS_ASSERT(lbl, prop, msg)
`define KRS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/krs_pkg.sv =====
// Types and constants of the keyed repeat suppressor.
package krs_pkg;

  localparam int unsigned SlotCountDef = 8;
  localparam int unsigned KeyW         = 32;
  localparam int unsigned TimeW        = 64;
  localparam int unsigned CountW       = 32;
  localparam int unsigned AddrW        = 4;
  localparam int unsigned DataW        = 64;

  localparam logic [TimeW-1:0] IntervalReset = 64'd10000000;

  // register index bit of paddr (registers sit at 8*i)
  localparam logic REG_INTERVAL = 1'b0;

  typedef enum logic {
    OP_CHECK = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIFF,
    ST_JUDGE
  } st_e;

endpackage

// ===== rtl/core/keyed_repeat_suppressor.sv =====
// Keyed repeat suppressor: slot table with oldest-slot replacement.
//
//   channel   handshake              payload
//   check in  start / busy           opcode_i, event_key_i, now_time_i
//   result    done_o (one cycle)     suppressed_o, repeats_reported_o, suppressed_total_o
//   config    APB psel/penable/...   repeat_interval at paddr 0, 64-bit data
//
// A check with a nonzero key keeps busy high while one slot
// is compared per cycle through the single read port of the slot store, then the
// shared 64-bit subtractor forms now minus last and compares it with the interval.
// Clear and zero-key items strobe their word the cycle after acceptance.
// Reset empties the table at once through per-slot valid bits; no clearing pass.
// The receiver cannot stall: done_o is high for exactly one cycle per item.
`include "assert_macros.svh"

module keyed_repeat_suppressor #(
  parameter int unsigned SLOT_COUNT = krs_pkg::SlotCountDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // check/clear items
  input  logic                        start,
  output logic                        busy,
  input  logic                        opcode_i,
  input  logic [krs_pkg::KeyW-1:0]    event_key_i,
  input  logic [krs_pkg::TimeW-1:0]   now_time_i,
  // results
  output logic                        done_o,
  output logic                        suppressed_o,
  output logic [krs_pkg::CountW-1:0]  repeats_reported_o,
  output logic [krs_pkg::CountW-1:0]  suppressed_total_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [krs_pkg::AddrW-1:0]   paddr,
  input  logic [krs_pkg::DataW-1:0]   pwdata,
  output logic [krs_pkg::DataW-1:0]   prdata,
  output logic                        pready
);
  import krs_pkg::*;

  localparam int unsigned IdxW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned ScanW = $clog2(SLOT_COUNT + 1);
  localparam logic [ScanW-1:0] ScanEnd = ScanW'(SLOT_COUNT);
  localparam logic [IdxW-1:0]  LastIdx = IdxW'(SLOT_COUNT - 1);

  // slot store
  logic [KeyW-1:0]   key_mem  [SLOT_COUNT];
  logic [TimeW-1:0]  time_mem [SLOT_COUNT];
  logic [CountW-1:0] rep_mem  [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_q;

  st_e state_q, state_d;

  logic [KeyW-1:0]   key_q;
  logic [TimeW-1:0]  now_q;
  logic [TimeW-1:0]  interval_q;
  logic [CountW-1:0] total_q;

  logic [ScanW-1:0]  rd_cnt_q;
  logic              cmp_vld_q;
  logic [IdxW-1:0]   cmp_idx_q;
  logic [KeyW-1:0]   rd_key_q;
  logic [TimeW-1:0]  rd_time_q;
  logic [CountW-1:0] rd_rep_q;
  logic              rd_vld_q;

  logic [IdxW-1:0]   vic_idx_q;
  logic [TimeW-1:0]  vic_time_q;
  logic [IdxW-1:0]   sel_idx_q;
  logic              sel_match_q;
  logic [TimeW-1:0]  sel_last_q;
  logic [CountW-1:0] sel_rep_q;
  logic [TimeW-1:0]  diff_q;

  logic              done_q;
  logic              supp_q;
  logic [CountW-1:0] rep_out_q;

  logic              accept, acc_check, acc_other;
  logic              rd_en, scan_stop, wr_supp, wr_pass, cfg_wr;
  logic [IdxW-1:0]   rd_addr, vic_idx_nx;
  logic [KeyW-1:0]   eff_key;
  logic [TimeW-1:0]  eff_last;
  logic [CountW-1:0] eff_rep;
  logic              key_eq, hit, take_vic, borrow, supp;
  logic [TimeW-1:0]  sub_a, sub_b;
  logic [TimeW:0]    sub_res;

  // ---------------------------------------------------------------
  // datapath
  assign accept    = start && !busy;
  assign acc_check = accept && (opcode_i == OP_CHECK) && (event_key_i != '0);
  assign acc_other = accept && !acc_check;
  assign rd_addr   = rd_cnt_q[IdxW-1:0];

  // slots that were never written or were cleared read as empty
  assign eff_key  = rd_vld_q ? rd_key_q  : '0;
  assign eff_last = rd_vld_q ? rd_time_q : '0;
  assign eff_rep  = rd_vld_q ? rd_rep_q  : '0;

  assign key_eq = (eff_key == key_q);
  assign hit    = cmp_vld_q && (key_eq || (eff_key == '0));

  // shared subtractor: victim age compare, elapsed time, window compare
  always_comb begin
    case (state_q)
      ST_SCAN: begin
        sub_a = eff_last;
        sub_b = vic_time_q;
      end
      ST_DIFF: begin
        sub_a = now_q;
        sub_b = sel_last_q;
      end
      default: begin
        sub_a = diff_q;
        sub_b = interval_q;
      end
    endcase
  end

  assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow  = sub_res[TimeW];

  // strictly older wins, so ties keep the lowest index
  assign take_vic   = cmp_vld_q && ((cmp_idx_q == '0) || borrow);
  assign vic_idx_nx = take_vic ? cmp_idx_q : vic_idx_q;
  assign scan_stop  = hit || (cmp_vld_q && (cmp_idx_q == LastIdx));

  assign supp = sel_match_q && borrow;

  // ---------------------------------------------------------------
  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc_check) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_stop) state_d = ST_DIFF;
      end
      ST_DIFF:  state_d = ST_JUDGE;
      ST_JUDGE: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = (state_q != ST_IDLE);
    rd_en   = (state_q == ST_SCAN) && (rd_cnt_q != ScanEnd) && !scan_stop;
    wr_supp = (state_q == ST_JUDGE) && supp;
    wr_pass = (state_q == ST_JUDGE) && !supp;
  end

  assign cfg_wr = psel && penable && pwrite && pready;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      valid_q    <= '0;
      total_q    <= '0;
      interval_q <= IntervalReset;
      done_q     <= 1'b0;
      rd_cnt_q   <= '0;
      cmp_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      done_q    <= acc_other || (state_q == ST_JUDGE);
      cmp_vld_q <= rd_en;
      if (rd_en) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end else if (state_q != ST_SCAN) begin
        rd_cnt_q <= '0;
      end
      if (accept && (opcode_i == OP_CLEAR)) begin
        valid_q <= '0;
        total_q <= '0;
      end
      if (wr_pass) valid_q[sel_idx_q] <= 1'b1;
      if (wr_supp) total_q <= total_q + 1'b1;
      if (cfg_wr && (paddr[3] == REG_INTERVAL)) interval_q <= pwdata;
    end
  end

  // item and scan payload
  always_ff @(posedge clk_i) begin
    if (acc_check) begin
      key_q <= event_key_i;
      now_q <= now_time_i;
    end
    if (rd_en) cmp_idx_q <= rd_addr;
    if (state_q == ST_SCAN) begin
      vic_idx_q <= vic_idx_nx;
      if (take_vic) vic_time_q <= eff_last;
      if (hit) begin
        sel_idx_q   <= cmp_idx_q;
        sel_match_q <= key_eq;
        sel_last_q  <= eff_last;
        sel_rep_q   <= eff_rep;
      end else if (scan_stop) begin
        // table full: replace the oldest slot
        sel_idx_q   <= vic_idx_nx;
        sel_match_q <= 1'b0;
        sel_last_q  <= eff_last;
        sel_rep_q   <= '0;
      end
    end
    if (state_q == ST_DIFF) diff_q <= sub_res[TimeW-1:0];
    if (acc_other) begin
      supp_q    <= 1'b0;
      rep_out_q <= '0;
    end else if (state_q == ST_JUDGE) begin
      supp_q    <= supp;
      rep_out_q <= supp ? '0 : (sel_match_q ? sel_rep_q : '0);
    end
  end

  // slot store, one read and one write port
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_key_q  <= key_mem[rd_addr];
      rd_time_q <= time_mem[rd_addr];
      rd_rep_q  <= rep_mem[rd_addr];
      rd_vld_q  <= valid_q[rd_addr];
    end
    if (wr_pass) begin
      key_mem[sel_idx_q]  <= key_q;
      time_mem[sel_idx_q] <= now_q;
      rep_mem[sel_idx_q]  <= '0;
    end else if (wr_supp) begin
      rep_mem[sel_idx_q]  <= sel_rep_q + 1'b1;
    end
  end

  // ---------------------------------------------------------------
  // outputs
  assign done_o             = done_q;
  assign suppressed_o       = supp_q;
  assign repeats_reported_o = rep_out_q;
  assign suppressed_total_o = total_q;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_INTERVAL) ? interval_q : '0;

  // ---------------------------------------------------------------
  // assertions
  `KRS_ASSERT(a_done_not_busy, done_o |-> !busy, "result word strobed while busy")
  `KRS_ASSERT(a_judge_strobes, (state_q == ST_JUDGE) |=> done_o, "decision gave no word")
  `KRS_ASSERT(a_accept_moves, (start && !busy) |=> (busy || done_o), "accepted word dropped")

endmodule
